FILE: src/tchd_pkg.sv
// Shared types, codes and helper functions for the two-car hall call dispatcher.
`default_nettype none

package tchd_pkg;

	// Floors are four bits wide; the mirror of a floor is its complement
	localparam int FLOOR_W = 4;
	localparam int FLOOR_COUNT = 16;
	localparam int DIR_W = 2;
	localparam int CAR_W = 2;

	// Input stream widths (tdata padded to whole bytes)
	localparam int IN_FIELDS_W = 5 * FLOOR_W + 2 * DIR_W;
	localparam int IN_DATA_W = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = CAR_W + FLOOR_W;
	localparam int OUT_DATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

	typedef logic [FLOOR_W-1:0] floor_t;
	typedef logic [DIR_W-1:0] dir_t;
	typedef logic [CAR_W-1:0] car_t;

	// Car motion codes
	localparam dir_t MOT_STOP = 2'd0;
	localparam dir_t MOT_UP = 2'd1;
	localparam dir_t MOT_DOWN = 2'd2;
	// unused code: neither stopped, up nor down
	localparam dir_t MOT_SPARE = 2'd3;

	// Call direction codes
	localparam logic CALL_UP = 1'b0;
	localparam logic CALL_DOWN = 1'b1;

	// Assignment codes
	localparam car_t CAR_NONE = 2'd0;
	localparam car_t CAR_A = 2'd1;
	localparam car_t CAR_B = 2'd2;

	// One hall call with the state of both cars
	typedef struct packed {
		floor_t car_b_target;
		dir_t car_b_dir;
		floor_t car_b_floor;
		floor_t car_a_target;
		dir_t car_a_dir;
		floor_t car_a_floor;
		floor_t call_floor;
		logic action;
	} hall_call_t;

	// Dispatch decision
	typedef struct packed {
		floor_t new_target;
		car_t assigned_car;
	} dispatch_t;

	// Down calls are handled as up calls with the floor order reversed
	function automatic floor_t mirror_floor(input floor_t f, input logic mir);
		return mir ? ~f : f;
	endfunction

	// Mirrored view swaps up and down; stopped and the unused code stay
	function automatic dir_t mirror_dir(input dir_t d, input logic mir);
		dir_t r;
		r = d;
		if (mir && d == MOT_UP) begin
			r = MOT_DOWN;
		end else if (mir && d == MOT_DOWN) begin
			r = MOT_UP;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: src/tchd_decide.sv
// Combinational dispatch rules for one hall call across two cars.
`default_nettype none

module tchd_decide
	import tchd_pkg::*;
(
	input  wire hall_call_t call,
	output dispatch_t       result
);

	floor_t f, fa, ta, fb, tb;
	dir_t da, db;
	car_t car;
	logic mir;

	// Map the call into the up-call frame
	assign mir = (call.action == CALL_DOWN);
	assign f = mirror_floor(call.call_floor, mir);
	assign fa = mirror_floor(call.car_a_floor, mir);
	assign ta = mirror_floor(call.car_a_target, mir);
	assign fb = mirror_floor(call.car_b_floor, mir);
	assign tb = mirror_floor(call.car_b_target, mir);
	assign da = mirror_dir(call.car_a_dir, mir);
	assign db = mirror_dir(call.car_b_dir, mir);

	// Up-call rule chain, first match wins
	always_comb begin
		car = CAR_NONE;
		priority if (fa == f || fb == f) begin
			car = CAR_NONE;
		end else if ((fa < f && da == MOT_UP && ta > f) ||
			(fb < f && db == MOT_UP && tb > f)) begin
			// a car going up will pass the floor anyway
			car = CAR_NONE;
		end else if (f > fa && f > fb) begin
			if (da != MOT_DOWN && db != MOT_DOWN) begin
				if (fa > fb) begin
					car = CAR_A;
				end else if (fa < fb) begin
					car = CAR_B;
				end else begin
					car = (da == MOT_UP) ? CAR_A : CAR_B;
				end
			end else if (da == MOT_UP) begin
				car = CAR_A;
			end else if (db == MOT_UP) begin
				car = CAR_B;
			end else if (da == MOT_STOP) begin
				car = CAR_A;
			end else if (db == MOT_STOP) begin
				car = CAR_B;
			end
		end else if (fa > f && fb > f) begin
			if (da == MOT_STOP && db == MOT_STOP) begin
				car = (fa < fb) ? CAR_A : CAR_B;
			end else if (da == MOT_STOP) begin
				car = CAR_A;
			end else if (db == MOT_STOP) begin
				car = CAR_B;
			end
		end else if (fa < f) begin
			// first below, second above
			if (da != MOT_DOWN) begin
				car = CAR_A;
			end else if (db != MOT_UP && tb > f) begin
				car = CAR_B;
			end
		end else begin
			// first above, second below
			if (db != MOT_DOWN) begin
				car = CAR_B;
			end else if (da != MOT_UP && ta > f) begin
				car = CAR_A;
			end
		end
	end

	assign result.assigned_car = car;
	assign result.new_target = (car != CAR_NONE) ? call.call_floor : '0;

endmodule

`default_nettype wire

FILE: src/two_car_hall_call_dispatch.sv
// Pipeline: input register, then result register, with the dispatch rules between them as
// one compare tree. Throughput: one call per cycle unless the output stalls; the input
// register refills whenever the result register moves on or is empty, so a stalled output
// holds one result and one waiting call.
// Reset: arst_n clears both valid flags asynchronously; no clearing pass, ready right away.
`default_nettype none

module two_car_hall_call_dispatch
	import tchd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// call_floor, car_a_floor, car_a_dir, car_a_target, car_b_floor, car_b_dir, car_b_target
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// action
	input  wire logic                  s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// assigned_car, new_target, zero pad
	output logic [OUT_DATA_W-1:0]      m_tdata
);

	hall_call_t call_s1;
	dispatch_t result, result_s2;
	logic valid_s1, valid_s2;
	logic adv;

	// Result register moves when empty or taken
	assign adv = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv;

	// Control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			call_s1 <= {s_tdata[IN_FIELDS_W-1:0], s_tuser};
		end
		if (adv && valid_s1) begin
			result_s2 <= result;
		end
	end

	tchd_decide u_decide (
		.call   (call_s1),
		.result (result)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata = {{(OUT_DATA_W-OUT_FIELDS_W){1'b0}}, result_s2};

endmodule

`default_nettype wire

FILE: src/tchd_checker.sv
// Port-level checker for the dispatcher, bound to the top level.
`default_nettype none

module tchd_checker
	import tchd_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_tvalid,
	input wire logic                  s_tready,
	input wire logic                  m_tvalid,
	input wire logic                  m_tready,
	input wire logic [OUT_DATA_W-1:0] m_tdata
);

	// Stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// A result with no car assigned carries a zero target
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[CAR_W-1:0] == CAR_NONE |-> m_tdata[OUT_FIELDS_W-1:CAR_W] == '0)
		else $error("target set without assignment");

	// Only defined car codes and clean padding
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[CAR_W-1:0] <= CAR_B && m_tdata[OUT_DATA_W-1:OUT_FIELDS_W] == '0)
		else $error("bad car code or pad bits");

	// A call passes the input and result registers to the output when the output keeps flowing
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) ##1 m_tready |=> m_tvalid)
		else $error("result missing after transfer");

	// Input is held off only behind a stalled result
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output stall");

endmodule

bind two_car_hall_call_dispatch tchd_checker u_tchd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

FILE: test/tchd_dispatch_checker.sv
// Checker for the two-car hall call dispatcher: predicts each decision and compares results.
`timescale 1ns / 1ps

module tchd_dispatch_checker
	import tchd_pkg::*;
#(
	parameter int CALL_DATA_W = 24
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	input  wire logic                   s_tready,
	// call_floor, car_a_floor, car_a_dir, car_a_target, car_b_floor, car_b_dir, car_b_target
	input  wire logic [CALL_DATA_W-1:0] s_tdata,
	// action
	input  wire logic                   s_tuser,
	input  wire logic                   m_tvalid,
	input  wire logic                   m_tready,
	// assigned_car, new_target, zero pad
	input  wire logic [OUT_DATA_W-1:0]  m_tdata,
	output int                          errors,
	output int                          pending
);

	typedef struct packed {
		car_t   car;
		floor_t target;
	} decision_t;

	decision_t expected_decisions[$];
	int        reported;

	// Down calls are judged as up calls on a reversed building
	function automatic floor_t flip_floor(input floor_t f, input logic down_call);
		return down_call ? floor_t'(4'd15 - f) : f;
	endfunction

	function automatic dir_t flip_dir(input dir_t d, input logic down_call);
		if (down_call && d == MOT_UP) begin
			return MOT_DOWN;
		end
		if (down_call && d == MOT_DOWN) begin
			return MOT_UP;
		end
		return d;
	endfunction

	// Which car takes the call, and its new final target
	function automatic decision_t predict_dispatch(input logic down_call,
			input logic [CALL_DATA_W-1:0] bits);
		floor_t    call, f, fa, ta, fb, tb;
		dir_t      da, db;
		car_t      car;
		decision_t d;
		call = bits[3:0];
		f  = flip_floor(call, down_call);
		fa = flip_floor(bits[7:4], down_call);
		da = flip_dir(bits[9:8], down_call);
		ta = flip_floor(bits[13:10], down_call);
		fb = flip_floor(bits[17:14], down_call);
		db = flip_dir(bits[19:18], down_call);
		tb = flip_floor(bits[23:20], down_call);
		car = CAR_NONE;
		if (fa == f || fb == f) begin
			car = CAR_NONE;
		end else if ((fa < f && da == MOT_UP && ta > f) ||
				(fb < f && db == MOT_UP && tb > f)) begin
			// a car heading that way passes the floor anyway
			car = CAR_NONE;
		end else if (fa < f && fb < f) begin
			if (da != MOT_DOWN && db != MOT_DOWN) begin
				if (fa > fb) car = CAR_A;
				else if (fa < fb) car = CAR_B;
				else car = (da == MOT_UP) ? CAR_A : CAR_B;
			end else if (da == MOT_UP) car = CAR_A;
			else if (db == MOT_UP) car = CAR_B;
			else if (da == MOT_STOP) car = CAR_A;
			else if (db == MOT_STOP) car = CAR_B;
		end else if (fa > f && fb > f) begin
			if (da == MOT_STOP && db == MOT_STOP) car = (fa < fb) ? CAR_A : CAR_B;
			else if (da == MOT_STOP) car = CAR_A;
			else if (db == MOT_STOP) car = CAR_B;
		end else if (fa < f) begin
			if (da != MOT_DOWN) car = CAR_A;
			else if (db != MOT_UP && tb > f) car = CAR_B;
		end else begin
			if (db != MOT_DOWN) car = CAR_B;
			else if (da != MOT_UP && ta > f) car = CAR_A;
		end
		d.car = car;
		d.target = (car != CAR_NONE) ? call : floor_t'(0);
		return d;
	endfunction

	// Record each input transfer, check each output transfer
	always @(posedge clk or negedge arst_n) begin
		decision_t want;
		car_t      got_car;
		floor_t    got_target;
		logic [OUT_DATA_W-CAR_W-FLOOR_W-1:0] got_pad;
		if (!arst_n) begin
			expected_decisions.delete();
			errors <= 0;
			reported <= 0;
			pending <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_decisions.push_back(predict_dispatch(s_tuser, s_tdata));
			end
			if (m_tvalid && m_tready) begin
				got_car = m_tdata[CAR_W-1:0];
				got_target = m_tdata[CAR_W+FLOOR_W-1:CAR_W];
				got_pad = m_tdata[OUT_DATA_W-1:CAR_W+FLOOR_W];
				if (expected_decisions.size() == 0) begin
					errors <= errors + 1;
					reported <= reported + 1;
					if (reported < 10) begin
						$display("%0t: result with none expected: car %0d target %0d",
							$realtime, got_car, got_target);
					end
				end else begin
					want = expected_decisions.pop_front();
					if (got_car != want.car || got_target != want.target || got_pad != '0) begin
						errors <= errors + 1;
						reported <= reported + 1;
						if (reported < 10) begin
							$display({"%0t: mismatch: expected car %0d target %0d, ",
								"got car %0d target %0d pad %0h"},
								$realtime, want.car, want.target, got_car, got_target,
								got_pad);
						end
					end
				end
			end
			pending <= expected_decisions.size();
		end
	end

endmodule

FILE: test/tb_two_car_hall_call_dispatch.sv
// Testbench top for the two-car hall call dispatcher: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_two_car_hall_call_dispatch;
	import tchd_pkg::*;

	// Seven call fields packed from the lowest bit, rounded up to whole bytes
	localparam int CALL_DATA_W = ((5 * FLOOR_W + 2 * DIR_W + 7) / 8) * 8;
	localparam int RANDOM_CALLS = 1500;
	localparam int HOLD_CYCLES = 400;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	// call_floor, car_a_floor, car_a_dir, car_a_target, car_b_floor, car_b_dir, car_b_target
	logic [CALL_DATA_W-1:0] s_tdata = '0;
	// action
	logic                   s_tuser = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	// assigned_car, new_target, zero pad
	logic [OUT_DATA_W-1:0]  m_tdata;
	int                     errors;
	int                     pending;

	int tx_idle_pct = 26;
	int rx_idle_pct = 80;
	bit hold_req = 1'b0;

	always #4 clk = ~clk;

	two_car_hall_call_dispatch dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	tchd_dispatch_checker #(.CALL_DATA_W(CALL_DATA_W)) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.errors(errors),
		.pending(pending)
	);

	// Offer one call; returns at the edge where it is transferred
	task automatic send_call(input logic down_call, input floor_t f,
			input floor_t fa, input dir_t da, input floor_t ta,
			input floor_t fb, input dir_t db, input floor_t tb);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= down_call;
		s_tdata <= {tb, db, fb, ta, da, fa, f};
		do @(posedge clk); while (!s_tready);
	endtask

	function automatic dir_t random_dir();
		// the unused motion code now and then
		return ($urandom_range(0, 9) == 0) ? MOT_SPARE : dir_t'($urandom_range(0, 2));
	endfunction

	// Output flow control, with one long hold-off on request
	initial begin : rx_flow
		int i;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				for (i = 0; i < HOLD_CYCLES; i++) @(posedge clk);
				hold_req = 1'b0;
			end
			m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// Reset, directed calls, random calls, drain and verdict
	initial begin : stimulus
		int n;
		logic down_call;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes of the fields
		send_call(CALL_UP, 4'd0, 4'd0, MOT_STOP, 4'd0, 4'd0, MOT_STOP, 4'd0);
		send_call(CALL_DOWN, 4'd15, 4'd15, MOT_SPARE, 4'd15, 4'd15, MOT_SPARE, 4'd15);
		send_call(CALL_UP, 4'd15, 4'd0, MOT_UP, 4'd14, 4'd14, MOT_DOWN, 4'd0);
		send_call(CALL_DOWN, 4'd0, 4'd15, MOT_DOWN, 4'd1, 4'd1, MOT_UP, 4'd15);
		// car already at the floor
		send_call(CALL_UP, 4'd8, 4'd8, MOT_DOWN, 4'd2, 4'd3, MOT_STOP, 4'd3);
		// car passing the floor anyway
		send_call(CALL_UP, 4'd8, 4'd3, MOT_UP, 4'd12, 4'd14, MOT_STOP, 4'd14);
		send_call(CALL_DOWN, 4'd3, 4'd10, MOT_DOWN, 4'd1, 4'd0, MOT_STOP, 4'd0);
		// both cars below: higher one, equal floors, then motion order
		send_call(CALL_UP, 4'd8, 4'd5, MOT_STOP, 4'd5, 4'd3, MOT_UP, 4'd6);
		send_call(CALL_UP, 4'd8, 4'd4, MOT_UP, 4'd6, 4'd4, MOT_STOP, 4'd4);
		send_call(CALL_UP, 4'd8, 4'd4, MOT_STOP, 4'd4, 4'd4, MOT_UP, 4'd7);
		send_call(CALL_UP, 4'd8, 4'd2, MOT_UP, 4'd5, 4'd6, MOT_DOWN, 4'd1);
		send_call(CALL_UP, 4'd8, 4'd6, MOT_DOWN, 4'd1, 4'd2, MOT_STOP, 4'd2);
		send_call(CALL_UP, 4'd8, 4'd6, MOT_DOWN, 4'd1, 4'd2, MOT_DOWN, 4'd0);
		// both cars above
		send_call(CALL_UP, 4'd8, 4'd10, MOT_STOP, 4'd10, 4'd12, MOT_STOP, 4'd12);
		send_call(CALL_UP, 4'd8, 4'd11, MOT_STOP, 4'd11, 4'd11, MOT_STOP, 4'd11);
		send_call(CALL_UP, 4'd8, 4'd10, MOT_UP, 4'd13, 4'd12, MOT_STOP, 4'd12);
		send_call(CALL_UP, 4'd8, 4'd10, MOT_UP, 4'd13, 4'd12, MOT_DOWN, 4'd9);
		// first below, second above
		send_call(CALL_UP, 4'd8, 4'd3, MOT_STOP, 4'd3, 4'd12, MOT_UP, 4'd14);
		send_call(CALL_UP, 4'd8, 4'd3, MOT_DOWN, 4'd0, 4'd12, MOT_STOP, 4'd10);
		send_call(CALL_UP, 4'd8, 4'd3, MOT_DOWN, 4'd0, 4'd12, MOT_DOWN, 4'd5);
		// first above, second below
		send_call(CALL_UP, 4'd8, 4'd12, MOT_UP, 4'd15, 4'd2, MOT_STOP, 4'd2);
		send_call(CALL_UP, 4'd8, 4'd12, MOT_STOP, 4'd12, 4'd2, MOT_DOWN, 4'd0);
		send_call(CALL_UP, 4'd8, 4'd12, MOT_DOWN, 4'd5, 4'd2, MOT_DOWN, 4'd0);
		// unused motion code on both cars
		send_call(CALL_UP, 4'd8, 4'd5, MOT_SPARE, 4'd9, 4'd3, MOT_SPARE, 4'd12);
		send_call(CALL_DOWN, 4'd6, 4'd12, MOT_SPARE, 4'd2, 4'd3, MOT_SPARE, 4'd9);

		// random calls in three flow-control phases
		for (n = 0; n < RANDOM_CALLS; n++) begin
			if (n == RANDOM_CALLS / 3) begin
				tx_idle_pct = 80;
				rx_idle_pct = 26;
			end else if (n == 2 * RANDOM_CALLS / 3) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end else if (n == 3 * RANDOM_CALLS / 4) begin
				hold_req = 1'b1;
			end
			down_call = 1'($urandom_range(0, 1));
			send_call(down_call, floor_t'($urandom_range(0, 15)),
				floor_t'($urandom_range(0, 15)), random_dir(), floor_t'($urandom_range(0, 15)),
				floor_t'($urandom_range(0, 15)), random_dir(), floor_t'($urandom_range(0, 15)));
		end
		s_tvalid <= 1'b0;

		// drain, then idle before the verdict
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Run limit
	initial begin : watchdog
		#2000000;
		$display("tb: failure");
		$finish;
	end

endmodule

FILE: files.f
src/tchd_pkg.sv
src/tchd_decide.sv
src/two_car_hall_call_dispatch.sv
src/tchd_checker.sv
test/tchd_dispatch_checker.sv
test/tb_two_car_hall_call_dispatch.sv
